// ===== sv/dtp_pkg.sv =====
package dtp_pkg;

  // Parse phase of the options area.
  typedef enum logic [2:0] {
    PH_COOKIE = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_VALUE  = 3'd3,
    PH_IGNORE = 3'd4
  } phase_t;

  // Classification reported for each byte.
  typedef enum logic [2:0] {
    KIND_COOKIE  = 3'd0,
    KIND_PAD     = 3'd1,
    KIND_CODE    = 3'd2,
    KIND_LENGTH  = 3'd3,
    KIND_VALUE   = 3'd4,
    KIND_END     = 3'd5,
    KIND_IGNORED = 3'd6
  } kind_t;

  // Sticky status of the current area.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_COOKIE = 2'd1,
    ST_TRUNCATED  = 2'd2,
    ST_BAD_TYPE   = 2'd3
  } status_t;

  localparam logic [7:0] CODE_PAD      = 8'd0;
  localparam logic [7:0] CODE_END      = 8'd255;
  localparam logic [7:0] CODE_MSG_TYPE = 8'd53;
  localparam logic [7:0] COUNT_MAX     = 8'd255;

  // Magic cookie that opens the options area.
  localparam logic [7:0] COOKIE_BYTES [4] = '{8'd99, 8'd130, 8'd83, 8'd99};

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0] byte_kind;
    logic [7:0] opt_code;
    logic [7:0] option_length;
    logic [7:0] value_index;
    logic       target_hit;
    logic [7:0] option_count;
    logic [7:0] message_type;
    logic       message_type_valid;
    logic       cookie_ok;
    logic [1:0] status;
    logic       packet_done;
  } result_t;

  // Handshake between the stages and the parse core.
  typedef struct packed {
    logic valid;
    logic fire;
  } stage_ctl_t;

endpackage

// ===== sv/dtp_ifs.sv =====
interface dtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dtp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] byte_kind;
  logic [7:0] opt_code;
  logic [7:0] option_length;
  logic [7:0] value_index;
  logic       target_hit;
  logic [7:0] option_count;
  logic [7:0] message_type;
  logic       message_type_valid;
  logic       cookie_ok;
  logic [1:0] status;
  logic       packet_done;

  modport source (
    output valid, output byte_kind, output opt_code, output option_length,
    output value_index, output target_hit, output option_count, output message_type,
    output message_type_valid, output cookie_ok, output status, output packet_done,
    input ready
  );
  modport sink (
    input valid, input byte_kind, input opt_code, input option_length,
    input value_index, input target_hit, input option_count, input message_type,
    input message_type_valid, input cookie_ok, input status, input packet_done,
    output ready
  );
endinterface

// ===== sv/dtp_in_stage.sv =====
module dtp_in_stage (
  input  logic                clk,
  input  logic                rst,
  dtp_in_if.sink              bytes_in,
  input  logic                take,
  output dtp_pkg::stage_ctl_t ctl,
  output dtp_pkg::item_t      item
);

  logic valid;

  // The register frees up in the same cycle that its beat moves on.
  assign bytes_in.ready = !valid || take;
  assign ctl.valid      = valid;
  assign ctl.fire       = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (bytes_in.ready) begin
      valid <= bytes_in.valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (bytes_in.valid && bytes_in.ready) begin
      item.data_byte <= bytes_in.data_byte;
      item.last_byte <= bytes_in.last_byte;
    end
  end

endmodule

// ===== sv/dtp_parse_core.sv =====
module dtp_parse_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_data,
  input  logic               fire,
  input  dtp_pkg::item_t     item,
  output dtp_pkg::result_t   res
);

  dtp_pkg::phase_t  phase, phase_next;
  logic [1:0]       cookie_position, cookie_position_next;
  logic [7:0]       current_code, current_code_next;
  logic [7:0]       current_length, current_length_next;
  logic [7:0]       bytes_remaining, bytes_remaining_next;
  logic [7:0]       options_seen, options_seen_next;
  logic [7:0]       captured_type, captured_type_next;
  logic             type_captured, type_captured_next;
  logic             target_found, target_found_next;
  logic             in_target_option, in_target_option_next;
  dtp_pkg::status_t error_code, error_code_next;
  logic [7:0]       target_code;

  dtp_pkg::kind_t   kind;
  logic [7:0]       ocode, olen, vidx;
  logic             hit;
  logic [7:0]       count_inc, rem_dec;
  logic [7:0]       b;

  assign b         = item.data_byte;
  assign count_inc = (options_seen != dtp_pkg::COUNT_MAX) ? options_seen + 8'd1 : options_seen;
  assign rem_dec   = bytes_remaining - 8'd1;

  // One parse step: next state and the result for the byte in the input register.
  always_comb begin
    phase_next            = phase;
    cookie_position_next  = cookie_position;
    current_code_next     = current_code;
    current_length_next   = current_length;
    bytes_remaining_next  = bytes_remaining;
    options_seen_next     = options_seen;
    captured_type_next    = captured_type;
    type_captured_next    = type_captured;
    target_found_next     = target_found;
    in_target_option_next = in_target_option;
    error_code_next       = error_code;
    kind  = dtp_pkg::KIND_IGNORED;
    ocode = 8'd0;
    olen  = 8'd0;
    vidx  = 8'd0;
    hit   = 1'b0;

    unique case (phase)
      dtp_pkg::PH_COOKIE: begin
        kind = dtp_pkg::KIND_COOKIE;
        if (b != dtp_pkg::COOKIE_BYTES[cookie_position]) begin
          error_code_next = dtp_pkg::ST_BAD_COOKIE;
          phase_next      = dtp_pkg::PH_IGNORE;
        end else if (cookie_position == 2'd3) begin
          phase_next = dtp_pkg::PH_CODE;
        end else begin
          cookie_position_next = cookie_position + 2'd1;
          if (item.last_byte) begin
            error_code_next = dtp_pkg::ST_BAD_COOKIE;
          end
        end
      end
      dtp_pkg::PH_CODE: begin
        if (b == dtp_pkg::CODE_PAD) begin
          kind = dtp_pkg::KIND_PAD;
        end else if (b == dtp_pkg::CODE_END) begin
          kind       = dtp_pkg::KIND_END;
          phase_next = dtp_pkg::PH_IGNORE;
        end else begin
          kind                = dtp_pkg::KIND_CODE;
          ocode               = b;
          current_code_next   = b;
          current_length_next = 8'd0;
          if (target_code != 8'd0 && b == target_code && !target_found) begin
            target_found_next     = 1'b1;
            in_target_option_next = 1'b1;
          end else begin
            in_target_option_next = 1'b0;
          end
          phase_next = dtp_pkg::PH_LEN;
          if (item.last_byte) begin
            error_code_next = dtp_pkg::ST_TRUNCATED;
          end
        end
      end
      dtp_pkg::PH_LEN: begin
        kind                 = dtp_pkg::KIND_LENGTH;
        ocode                = current_code;
        olen                 = b;
        current_length_next  = b;
        bytes_remaining_next = b;
        if (current_code == dtp_pkg::CODE_MSG_TYPE && !type_captured &&
            error_code == dtp_pkg::ST_OK && b != 8'd1) begin
          error_code_next = dtp_pkg::ST_BAD_TYPE;
        end
        if (b == 8'd0) begin
          options_seen_next = count_inc;
          phase_next        = dtp_pkg::PH_CODE;
        end else begin
          phase_next = dtp_pkg::PH_VALUE;
          if (item.last_byte) begin
            error_code_next = dtp_pkg::ST_TRUNCATED;
          end
        end
      end
      dtp_pkg::PH_VALUE: begin
        kind  = dtp_pkg::KIND_VALUE;
        ocode = current_code;
        olen  = current_length;
        vidx  = current_length - bytes_remaining;
        hit   = in_target_option;
        if (current_code == dtp_pkg::CODE_MSG_TYPE && current_length == 8'd1 &&
            !type_captured && error_code == dtp_pkg::ST_OK) begin
          captured_type_next = b;
          type_captured_next = 1'b1;
        end
        bytes_remaining_next = rem_dec;
        if (rem_dec == 8'd0) begin
          options_seen_next = count_inc;
          phase_next        = dtp_pkg::PH_CODE;
        end else if (item.last_byte) begin
          error_code_next = dtp_pkg::ST_TRUNCATED;
        end
      end
      default: begin
        kind = dtp_pkg::KIND_IGNORED;
      end
    endcase

    // Cookie and truncation errors stop parsing for the rest of the area.
    if (error_code_next == dtp_pkg::ST_BAD_COOKIE || error_code_next == dtp_pkg::ST_TRUNCATED) begin
      phase_next = dtp_pkg::PH_IGNORE;
    end

    res.byte_kind          = kind;
    res.opt_code           = ocode;
    res.option_length      = olen;
    res.value_index        = vidx;
    res.target_hit         = hit;
    res.option_count       = options_seen_next;
    res.message_type       = captured_type_next;
    res.message_type_valid = type_captured_next;
    res.cookie_ok          = (error_code_next != dtp_pkg::ST_BAD_COOKIE);
    res.status             = error_code_next;
    res.packet_done        = item.last_byte;
  end

  // Target code register.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_code <= 8'd0;
    end else if (cfg_write) begin
      target_code <= cfg_data;
    end
  end

  // Parser state; the last byte of an area returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst || (fire && item.last_byte)) begin
      phase            <= dtp_pkg::PH_COOKIE;
      cookie_position  <= 2'd0;
      current_code     <= 8'd0;
      current_length   <= 8'd0;
      bytes_remaining  <= 8'd0;
      options_seen     <= 8'd0;
      captured_type    <= 8'd0;
      type_captured    <= 1'b0;
      target_found     <= 1'b0;
      in_target_option <= 1'b0;
      error_code       <= dtp_pkg::ST_OK;
    end else if (fire) begin
      phase            <= phase_next;
      cookie_position  <= cookie_position_next;
      current_code     <= current_code_next;
      current_length   <= current_length_next;
      bytes_remaining  <= bytes_remaining_next;
      options_seen     <= options_seen_next;
      captured_type    <= captured_type_next;
      type_captured    <= type_captured_next;
      target_found     <= target_found_next;
      in_target_option <= in_target_option_next;
      error_code       <= error_code_next;
    end
  end

  // The byte marked last always leaves the parser at the start of a new area.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.last_byte |=> phase == dtp_pkg::PH_COOKIE && options_seen == 8'd0)
    else $error("parser state not cleared after last byte");

  // Fatal errors keep the parser in the ignore phase.
  a_error_ignores: assert property (@(posedge clk) disable iff (rst)
    (error_code == dtp_pkg::ST_BAD_COOKIE || error_code == dtp_pkg::ST_TRUNCATED)
      |-> phase == dtp_pkg::PH_IGNORE)
    else $error("fatal error without ignore phase");

  // The value phase always has at least one byte left to take.
  a_value_nonempty: assert property (@(posedge clk) disable iff (rst)
    phase == dtp_pkg::PH_VALUE |-> bytes_remaining != 8'd0)
    else $error("value phase with no bytes remaining");

  // Only the first matching option can be marked.
  a_target_first: assert property (@(posedge clk) disable iff (rst)
    in_target_option |-> target_found)
    else $error("target option marked before it was found");

endmodule

// ===== sv/dtp_out_stage.sv =====
module dtp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dtp_pkg::result_t res,
  output logic             can_load,
  dtp_out_if.source        results
);

  logic             valid;
  dtp_pkg::result_t held;

  // A new beat may enter when the register is empty or being emptied.
  assign can_load      = !valid || results.ready;
  assign results.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  // Drive the payload from the held result.
  assign results.byte_kind          = held.byte_kind;
  assign results.opt_code           = held.opt_code;
  assign results.option_length      = held.option_length;
  assign results.value_index        = held.value_index;
  assign results.target_hit         = held.target_hit;
  assign results.option_count       = held.option_count;
  assign results.message_type       = held.message_type;
  assign results.message_type_valid = held.message_type_valid;
  assign results.cookie_ok          = held.cookie_ok;
  assign results.status             = held.status;
  assign results.packet_done        = held.packet_done;

endmodule

// ===== sv/dhcp_option_tlv_parser.sv =====
// Options-area parser for DHCP packets, one byte per beat.
// The bytes_in channel carries the options area starting at the magic cookie,
// with last_byte set on its final byte. The results channel returns one beat
// per input byte: its classification, the option it belongs to, running
// counts, the captured message type and a sticky status.
// The target option code is written through cfg_write and cfg_data; the user
// must write it only while the block is idle, as the block itself does not
// enforce this. The value bytes of its first occurrence are flagged.
// An accepted input beat passes through the input register, then through the
// parse logic into the output register. Throughput is one byte per cycle while
// the receiver keeps the results channel ready.
// Reset clears the parse state, the target code and the valid flags of both stage registers.
// The parse state also returns to its reset values after the byte marked last.
// When the receiver stalls, the output register holds its beat, the input
// register fills behind it, and bytes_in.ready drops until the results move.
module dhcp_option_tlv_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  dtp_in_if.sink     bytes_in,
  dtp_out_if.source  results
);

  dtp_pkg::stage_ctl_t ctl;
  dtp_pkg::item_t      item;
  dtp_pkg::result_t    res;
  logic                can_load;
  logic                take;

  // A byte is parsed when it is held and the output register can take its result.
  assign take = ctl.valid && can_load;

  dtp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .bytes_in (bytes_in),
    .take     (take),
    .ctl      (ctl),
    .item     (item)
  );

  dtp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .fire      (ctl.fire),
    .item      (item),
    .res       (res)
  );

  dtp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (ctl.fire),
    .res      (res),
    .can_load (can_load),
    .results  (results)
  );

endmodule
